// File: design/rsc_pkg.sv
// rsc_pkg: shared widths, request and status codes and controller state type
// for the refcounted slot cache table; no dependencies
`default_nettype none

package rsc_pkg;

    localparam int REQ_TYPE_W  = 2;
    localparam int LAYER_W     = 6;
    localparam int EXPERT_W    = 8;
    localparam int SLOT_W      = 3;
    localparam int STATUS_W    = 3;
    localparam int COUNT_W     = 32;
    localparam int RESIDENT_W  = 10;
    localparam int TOTAL_W     = 17;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 9;

    localparam logic [RESIDENT_W-1:0] RESIDENT_MAX = '1;
    localparam logic [TOTAL_W-1:0]    TOTAL_MAX    = '1;

    localparam logic [REQ_TYPE_W-1:0] REQ_LOOKUP    = 2'd0;
    localparam logic [REQ_TYPE_W-1:0] REQ_LOAD_DONE = 2'd1;
    localparam logic [REQ_TYPE_W-1:0] REQ_RELEASE   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_HIT      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FILL     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_LOADED   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FAILED   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOFREE   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_BADKEY   = 3'd5;
    localparam logic [STATUS_W-1:0] ST_RELEASED = 3'd6;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 3'd7;

    localparam logic [CFG_INDEX_W-1:0] CFG_LAYERS  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_EXPERTS = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SLOTS   = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } ctrl_state_t;

endpackage

`default_nettype wire

// File: design/rsc_ifs.sv
// rsc_req_if and rsc_rsp_if: valid/ready channels for request and result beats
// depends on rsc_pkg for field widths
`default_nettype none

interface rsc_req_if;
    import rsc_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [REQ_TYPE_W-1:0] req_type;
    logic [LAYER_W-1:0]    layer;
    logic [EXPERT_W-1:0]   expert_id;
    logic [SLOT_W-1:0]     slot_index;
    logic                  load_ok;

    modport source (
        output valid, req_type, layer, expert_id, slot_index, load_ok,
        input  ready
    );

    modport sink (
        input  valid, req_type, layer, expert_id, slot_index, load_ok,
        output ready
    );
endinterface

interface rsc_rsp_if;
    import rsc_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [STATUS_W-1:0]   status;
    logic [SLOT_W-1:0]     slot_out;
    logic [COUNT_W-1:0]    request_count;
    logic [COUNT_W-1:0]    hit_count;
    logic [COUNT_W-1:0]    miss_count;
    logic [RESIDENT_W-1:0] resident_slots;
    logic [TOTAL_W-1:0]    lease_total;

    modport source (
        output valid, status, slot_out, request_count, hit_count, miss_count,
               resident_slots, lease_total,
        input  ready
    );

    modport sink (
        input  valid, status, slot_out, request_count, hit_count, miss_count,
               resident_slots, lease_total,
        output ready
    );
endinterface

`default_nettype wire

// File: design/rsc_ram.sv
// rsc_ram: generic single-write, single-read synchronous ram with registered read
// no dependencies
`default_nettype none

module rsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: design/refcounted_slot_cache_table_top.sv
// refcounted_slot_cache_table_top: per-layer slot tag table with lease counts
// depends on rsc_pkg, rsc_ifs (rsc_req_if, rsc_rsp_if) and rsc_ram
// flow: an accepted request is registered and its slot-row ram row read; commit in
//   the execute state writes the modified row back and registers the result beat,
//   stalling while an earlier result beat is held; a new request waits for commit
// reset: rows read as empty through per-row valid flops cleared by rst_n,
//   counters zero, registers 64/256/8; no clearing pass
`default_nettype none

module refcounted_slot_cache_table_top #(
    parameter int MAX_LAYERS  = 64,
    parameter int MAX_SLOTS   = 8,
    parameter int MAX_EXPERTS = 256,
    parameter int LEASE_BITS  = 8
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [rsc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [rsc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    rsc_req_if.sink                               req,
    rsc_rsp_if.source                             rsp
);
    import rsc_pkg::*;

    localparam int LAYER_AW = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
    localparam int SLOT_AW  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam logic [LEASE_BITS-1:0] LEASE_MAX = '1;

    typedef struct packed {
        logic                  tag_valid;
        logic [EXPERT_W-1:0]   tag;
        logic                  allocated;
        logic                  loading;
        logic [LEASE_BITS-1:0] leases;
    } entry_t;

    typedef entry_t [MAX_SLOTS-1:0] row_t;

    typedef struct packed {
        logic [REQ_TYPE_W-1:0] req_type;
        logic [LAYER_W-1:0]    layer;
        logic [EXPERT_W-1:0]   expert_id;
        logic [SLOT_W-1:0]     slot_index;
        logic                  load_ok;
    } req_t;

    ctrl_state_t           state_reg;
    req_t                  req_reg;
    logic [6:0]            layers_reg;
    logic [8:0]            experts_reg;
    logic [3:0]            slots_reg;
    logic [MAX_LAYERS-1:0] row_valid_reg;
    logic [COUNT_W-1:0]    requests_reg, hits_reg, misses_reg;
    logic [COUNT_W-1:0]    requests_next, hits_next, misses_next;
    logic [RESIDENT_W-1:0] resident_reg, resident_next;
    logic [TOTAL_W-1:0]    total_reg, total_next;
    logic                  out_valid_reg;
    logic [STATUS_W-1:0]   status_reg, status_next;
    logic [SLOT_W-1:0]     slot_out_reg, slot_out_next;

    logic                  accept;
    logic                  commit;
    logic [LAYER_AW-1:0]   row_addr;
    logic [$bits(row_t)-1:0] ram_rdata;
    row_t                  row_cur, row_new;
    logic [31:0]           eff_layers, eff_experts, eff_slots_a, eff_slots;
    logic                  lay_ok, exp_ok, sidx_ok;
    logic [SLOT_AW-1:0]    slot_sel;
    logic                  found, chosen;
    logic [SLOT_AW-1:0]    hit_idx, pick_idx;

    assign accept   = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign commit   = (state_reg == S_EXEC) && (!out_valid_reg || rsp.ready);
    assign row_addr = LAYER_AW'(req_reg.layer);

    rsc_ram #(
        .WIDTH ($bits(row_t)),
        .DEPTH (MAX_LAYERS)
    ) u_row_ram (
        .clk   (clk),
        .we    (commit),
        .waddr (row_addr),
        .wdata (row_new),
        .re    (accept),
        .raddr (LAYER_AW'(req.layer)),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        eff_layers  = (32'(layers_reg) < 32'(MAX_LAYERS)) ? 32'(layers_reg)
                                                           : 32'(MAX_LAYERS);
        eff_experts = (32'(experts_reg) < 32'(MAX_EXPERTS)) ? 32'(experts_reg)
                                                             : 32'(MAX_EXPERTS);
        eff_slots_a = (32'(slots_reg) < 32'(MAX_SLOTS)) ? 32'(slots_reg)
                                                         : 32'(MAX_SLOTS);
        eff_slots   = (eff_slots_a < eff_experts) ? eff_slots_a : eff_experts;
    end

    always_comb
    begin
        row_cur  = row_valid_reg[row_addr] ? row_t'(ram_rdata) : '0;
        row_new  = row_cur;
        lay_ok   = 32'(req_reg.layer) < eff_layers;
        exp_ok   = 32'(req_reg.expert_id) < eff_experts;
        sidx_ok  = 32'(req_reg.slot_index) < eff_slots;
        slot_sel = SLOT_AW'(req_reg.slot_index);

        requests_next = requests_reg;
        hits_next     = hits_reg;
        misses_next   = misses_reg;
        resident_next = resident_reg;
        total_next    = total_reg;
        status_next   = ST_BADKEY;
        slot_out_next = '0;

        // first matching slot
        found   = 1'b0;
        hit_idx = '0;
        for (int i = MAX_SLOTS - 1; i >= 0; i--)
        begin
            if (32'(i) < eff_slots && !row_cur[i].loading && row_cur[i].allocated
                && row_cur[i].tag_valid && row_cur[i].tag == req_reg.expert_id)
            begin
                found   = 1'b1;
                hit_idx = SLOT_AW'(i);
            end
        end

        // first free slot, overridden by the last never-allocated free slot
        chosen   = 1'b0;
        pick_idx = '0;
        for (int i = 0; i < MAX_SLOTS; i++)
        begin
            if (32'(i) < eff_slots && row_cur[i].leases == '0 && !row_cur[i].loading
                && (!chosen || !row_cur[i].allocated))
            begin
                chosen   = 1'b1;
                pick_idx = SLOT_AW'(i);
            end
        end

        case (req_reg.req_type)
            REQ_LOOKUP:
            begin
                if (lay_ok && exp_ok)
                begin
                    requests_next = requests_reg + COUNT_W'(1);
                    if (found)
                    begin
                        hits_next     = hits_reg + COUNT_W'(1);
                        slot_out_next = SLOT_W'(hit_idx);
                        if (row_cur[hit_idx].leases != LEASE_MAX && total_reg != TOTAL_MAX)
                        begin
                            row_new[hit_idx].leases = row_cur[hit_idx].leases
                                                      + LEASE_BITS'(1);
                            total_next  = total_reg + TOTAL_W'(1);
                            status_next = ST_HIT;
                        end
                        else
                        begin
                            status_next = ST_OVERFLOW;
                        end
                    end
                    else if (!chosen)
                    begin
                        status_next = ST_NOFREE;
                    end
                    else
                    begin
                        if (!row_cur[pick_idx].allocated && resident_reg != RESIDENT_MAX)
                        begin
                            resident_next = resident_reg + RESIDENT_W'(1);
                        end
                        row_new[pick_idx].allocated = 1'b1;
                        row_new[pick_idx].tag_valid = 1'b0;
                        row_new[pick_idx].tag       = '0;
                        row_new[pick_idx].loading   = 1'b1;
                        status_next   = ST_FILL;
                        slot_out_next = SLOT_W'(pick_idx);
                    end
                end
            end
            REQ_LOAD_DONE:
            begin
                if (lay_ok && exp_ok && sidx_ok && row_cur[slot_sel].loading)
                begin
                    row_new[slot_sel].loading = 1'b0;
                    slot_out_next = req_reg.slot_index;
                    if (req_reg.load_ok)
                    begin
                        row_new[slot_sel].tag       = req_reg.expert_id;
                        row_new[slot_sel].tag_valid = 1'b1;
                        misses_next = misses_reg + COUNT_W'(1);
                        if (row_cur[slot_sel].leases != LEASE_MAX && total_reg != TOTAL_MAX)
                        begin
                            row_new[slot_sel].leases = row_cur[slot_sel].leases
                                                       + LEASE_BITS'(1);
                            total_next  = total_reg + TOTAL_W'(1);
                            status_next = ST_LOADED;
                        end
                        else
                        begin
                            status_next = ST_OVERFLOW;
                        end
                    end
                    else
                    begin
                        status_next = ST_FAILED;
                    end
                end
            end
            REQ_RELEASE:
            begin
                if (lay_ok && sidx_ok)
                begin
                    if (row_cur[slot_sel].leases != '0)
                    begin
                        row_new[slot_sel].leases = row_cur[slot_sel].leases
                                                   - LEASE_BITS'(1);
                    end
                    if (total_reg != '0)
                    begin
                        total_next = total_reg - TOTAL_W'(1);
                    end
                    status_next   = ST_RELEASED;
                    slot_out_next = req_reg.slot_index;
                end
            end
            default:
            begin
                status_next = ST_BADKEY;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            layers_reg    <= 7'd64;
            experts_reg   <= 9'd256;
            slots_reg     <= 4'd8;
            row_valid_reg <= '0;
            requests_reg  <= '0;
            hits_reg      <= '0;
            misses_reg    <= '0;
            resident_reg  <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_LAYERS:  layers_reg  <= cfg_wdata[6:0];
                    CFG_EXPERTS: experts_reg <= cfg_wdata[8:0];
                    CFG_SLOTS:   slots_reg   <= cfg_wdata[3:0];
                    default:     ;
                endcase
            end

            if (commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    if (commit)
                    begin
                        state_reg               <= S_IDLE;
                        row_valid_reg[row_addr] <= 1'b1;
                        requests_reg            <= requests_next;
                        hits_reg                <= hits_next;
                        misses_reg              <= misses_next;
                        resident_reg            <= resident_next;
                        total_reg               <= total_next;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= '{req_type:   req.req_type,
                         layer:      req.layer,
                         expert_id:  req.expert_id,
                         slot_index: req.slot_index,
                         load_ok:    req.load_ok};
        end
        if (commit)
        begin
            status_reg   <= status_next;
            slot_out_reg <= slot_out_next;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = status_reg;
    assign rsp.slot_out       = slot_out_reg;
    assign rsp.request_count  = requests_reg;
    assign rsp.hit_count      = hits_reg;
    assign rsp.miss_count     = misses_reg;
    assign rsp.resident_slots = resident_reg;
    assign rsp.lease_total    = total_reg;

    // one request in flight: an accepted beat is executed before the next
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_EXEC) && !req.ready)
        else $error("accepted beat not followed by execute");

    // a result beat appears only from a committed execute cycle
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(commit))
        else $error("result beat without execute");

    // a commit returns to idle with a result pending
    a_commit_done: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> (state_reg == S_IDLE) && out_valid_reg)
        else $error("commit did not present a result");

endmodule

`default_nettype wire

// File: tb/tb.sv
// tb: self-checking bench for refcounted_slot_cache_table_top; sends request beats
// under several register settings and compares every result beat with a local model
// depends on rsc_pkg and rsc_ifs (rsc_req_if, rsc_rsp_if)
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rsc_pkg::*;

    localparam int MAX_LAYERS  = 64;
    localparam int MAX_SLOTS   = 8;
    localparam int MAX_EXPERTS = 256;
    localparam int LEASE_BITS  = 8;
    localparam int SLOT_COUNT  = MAX_LAYERS * MAX_SLOTS;
    localparam int LEASE_LIMIT = (1 << LEASE_BITS) - 1;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_PAD   = 4;
    localparam logic [REQ_TYPE_W-1:0] REQ_UNUSED = 2'd3;

    typedef struct packed {
        logic [REQ_TYPE_W-1:0] kind;
        logic [LAYER_W-1:0]    layer;
        logic [EXPERT_W-1:0]   expert;
        logic [SLOT_W-1:0]     slot;
        logic                  ok;
    } table_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [SLOT_W-1:0]     slot;
        logic [COUNT_W-1:0]    requests;
        logic [COUNT_W-1:0]    hits;
        logic [COUNT_W-1:0]    misses;
        logic [RESIDENT_W-1:0] resident;
        logic [TOTAL_W-1:0]    leases;
    } table_rsp_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;

    rsc_req_if req_ch();
    rsc_rsp_if rsp_ch();

    refcounted_slot_cache_table_top #(
        .MAX_LAYERS  (MAX_LAYERS),
        .MAX_SLOTS   (MAX_SLOTS),
        .MAX_EXPERTS (MAX_EXPERTS),
        .LEASE_BITS  (LEASE_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    // local copy of the slot table
    logic [EXPERT_W-1:0] tag_expert [SLOT_COUNT];
    bit                  tag_valid  [SLOT_COUNT];
    bit                  allocated  [SLOT_COUNT];
    bit                  loading    [SLOT_COUNT];
    int unsigned         lease_cnt  [SLOT_COUNT];
    logic [EXPERT_W-1:0] fill_expert [SLOT_COUNT];
    logic [COUNT_W-1:0]  requests_cnt;
    logic [COUNT_W-1:0]  hits_cnt;
    logic [COUNT_W-1:0]  misses_cnt;
    int unsigned         resident_cnt;
    int unsigned         lease_sum;
    logic [6:0]          reg_layers;
    logic [8:0]          reg_experts;
    logic [3:0]          reg_slots;

    table_rsp_t table_results_q [$];
    table_rsp_t exp_rsp;

    int unsigned fail_count;
    int unsigned cycle_count;
    int unsigned items_sent;
    int unsigned results_checked;
    int unsigned settings_used;
    int unsigned status_seen [8];
    int unsigned rsp_hold_cycles;
    int unsigned stall_left;
    bit          gaps_on = 1'b1;
    bit          stalls_on = 1'b1;

    function automatic int unsigned live_layers();
        return (reg_layers < MAX_LAYERS) ? reg_layers : MAX_LAYERS;
    endfunction

    function automatic int unsigned live_experts();
        return (reg_experts < MAX_EXPERTS) ? reg_experts : MAX_EXPERTS;
    endfunction

    function automatic int unsigned live_slots();
        int unsigned n;
        int unsigned e;
        n = (reg_slots < MAX_SLOTS) ? reg_slots : MAX_SLOTS;
        e = live_experts();
        return (n < e) ? n : e;
    endfunction

    function automatic logic [STATUS_W-1:0] grant_lease(int unsigned k,
                                                        logic [STATUS_W-1:0] ok_status);
        if (lease_cnt[k] >= LEASE_LIMIT || lease_sum >= TOTAL_MAX)
            return ST_OVERFLOW;
        lease_cnt[k]++;
        lease_sum++;
        return ok_status;
    endfunction

    function automatic table_rsp_t predict_table(table_req_t r);
        table_rsp_t  o;
        int unsigned nslots;
        int unsigned base;
        int unsigned k;
        int unsigned pick;
        bit          layer_ok;
        bit          expert_ok;
        bit          found;
        bit          chosen;
        nslots    = live_slots();
        layer_ok  = r.layer < live_layers();
        expert_ok = r.expert < live_experts();
        base      = r.layer * MAX_SLOTS;
        found     = 1'b0;
        chosen    = 1'b0;
        pick      = 0;
        o         = '0;
        o.status  = ST_BADKEY;
        if (r.kind == REQ_LOOKUP && layer_ok && expert_ok)
        begin
            requests_cnt++;
            for (int i = 0; i < nslots; i++)
            begin
                k = base + i;
                if (!found && !loading[k] && allocated[k] && tag_valid[k] &&
                    tag_expert[k] == r.expert)
                begin
                    found  = 1'b1;
                    o.slot = SLOT_W'(i);
                end
            end
            if (found)
            begin
                hits_cnt++;
                o.status = grant_lease(base + o.slot, ST_HIT);
            end
            else
            begin
                // last never-allocated free slot, else first free slot
                for (int i = 0; i < nslots; i++)
                begin
                    k = base + i;
                    if (lease_cnt[k] == 0 && !loading[k] && (!chosen || !allocated[k]))
                    begin
                        chosen = 1'b1;
                        pick   = i;
                    end
                end
                if (!chosen)
                    o.status = ST_NOFREE;
                else
                begin
                    k = base + pick;
                    if (!allocated[k])
                    begin
                        allocated[k] = 1'b1;
                        if (resident_cnt < RESIDENT_MAX)
                            resident_cnt++;
                    end
                    tag_valid[k]   = 1'b0;
                    tag_expert[k]  = '0;
                    loading[k]     = 1'b1;
                    fill_expert[k] = r.expert;
                    o.status       = ST_FILL;
                    o.slot         = SLOT_W'(pick);
                end
            end
        end
        else if (r.kind == REQ_LOAD_DONE && layer_ok && expert_ok && r.slot < nslots)
        begin
            k = base + r.slot;
            if (loading[k])
            begin
                loading[k] = 1'b0;
                o.slot     = r.slot;
                if (r.ok)
                begin
                    tag_expert[k] = r.expert;
                    tag_valid[k]  = 1'b1;
                    misses_cnt++;
                    o.status = grant_lease(k, ST_LOADED);
                end
                else
                    o.status = ST_FAILED;
            end
        end
        else if (r.kind == REQ_RELEASE && layer_ok && r.slot < nslots)
        begin
            k = base + r.slot;
            if (lease_cnt[k] != 0)
                lease_cnt[k]--;
            if (lease_sum != 0)
                lease_sum--;
            o.status = ST_RELEASED;
            o.slot   = r.slot;
        end
        o.requests = requests_cnt;
        o.hits     = hits_cnt;
        o.misses   = misses_cnt;
        o.resident = RESIDENT_W'(resident_cnt);
        o.leases   = TOTAL_W'(lease_sum);
        return o;
    endfunction

    function automatic int unsigned idle_length();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [LAYER_W-1:0] pick_layer();
        int unsigned roll;
        int unsigned n;
        roll = $urandom_range(0, 99);
        n    = live_layers();
        if (roll < 70)
            return LAYER_W'($urandom_range(0, ((n < 4) ? n : 4) - 1));
        if (roll < 92)
            return LAYER_W'($urandom_range(0, n - 1));
        return LAYER_W'($urandom_range(0, 63));
    endfunction

    function automatic logic [EXPERT_W-1:0] pick_expert();
        int unsigned roll;
        int unsigned n;
        roll = $urandom_range(0, 99);
        n    = live_experts();
        if (roll < 75)
            return EXPERT_W'($urandom_range(0, ((n < 12) ? n : 12) - 1));
        if (roll < 90)
            return EXPERT_W'($urandom_range(0, n - 1));
        return EXPERT_W'($urandom_range(0, 255));
    endfunction

    function automatic table_req_t mk_req(logic [REQ_TYPE_W-1:0] kind, int unsigned layer,
                                          int unsigned expert, int unsigned slot, bit ok);
        table_req_t r;
        r.kind   = kind;
        r.layer  = LAYER_W'(layer);
        r.expert = EXPERT_W'(expert);
        r.slot   = SLOT_W'(slot);
        r.ok     = ok;
        return r;
    endfunction

    // mostly well-formed traffic: lookups on a small key set, load done for
    // slots really loading, releases of slots holding leases; some raw noise
    function automatic table_req_t random_req();
        table_req_t  r;
        int unsigned roll;
        int unsigned nslots;
        int unsigned base;
        int unsigned cand [$];
        roll = $urandom_range(0, 99);
        r    = $bits(table_req_t)'($urandom);
        if (roll < 8)
            return r;
        r.layer = pick_layer();
        nslots  = live_slots();
        base    = r.layer * MAX_SLOTS;
        if (roll >= 50 && roll < 72)
        begin
            for (int i = 0; i < nslots; i++)
                if (loading[base + i])
                    cand.push_back(i);
            if (cand.size() != 0)
            begin
                r.kind   = REQ_LOAD_DONE;
                r.slot   = SLOT_W'(cand[$urandom_range(0, cand.size() - 1)]);
                r.expert = ($urandom_range(0, 9) != 0) ? fill_expert[base + r.slot]
                                                       : pick_expert();
                r.ok     = $urandom_range(0, 6) != 0;
                return r;
            end
        end
        else if (roll >= 72)
        begin
            for (int i = 0; i < nslots; i++)
                if (lease_cnt[base + i] != 0)
                    cand.push_back(i);
            r.kind = REQ_RELEASE;
            if (cand.size() != 0 && $urandom_range(0, 9) != 0)
                r.slot = SLOT_W'(cand[$urandom_range(0, cand.size() - 1)]);
            else
                r.slot = SLOT_W'($urandom_range(0, 7));
            return r;
        end
        r.kind   = REQ_LOOKUP;
        r.expert = pick_expert();
        return r;
    endfunction

    task automatic send_req(input table_req_t r);
        int unsigned gap;
        req_ch.valid      <= 1'b1;
        req_ch.req_type   <= r.kind;
        req_ch.layer      <= r.layer;
        req_ch.expert_id  <= r.expert;
        req_ch.slot_index <= r.slot;
        req_ch.load_ok    <= r.ok;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        table_results_q.push_back(predict_table(r));
        items_sent++;
        gap = (gaps_on && $urandom_range(0, 99) < 35) ? idle_length() : 0;
        @(negedge clk);
        if (gap != 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic drain_results();
        req_ch.valid <= 1'b0;
        while (table_results_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_PAD) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic set_regs(int unsigned layers, int unsigned experts, int unsigned slots);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_LAYERS;
        cfg_wdata <= CFG_DATA_W'(layers);
        @(negedge clk);
        cfg_index <= CFG_EXPERTS;
        cfg_wdata <= CFG_DATA_W'(experts);
        @(negedge clk);
        cfg_index <= CFG_SLOTS;
        cfg_wdata <= CFG_DATA_W'(slots);
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
        reg_layers  = 7'(layers);
        reg_experts = 9'(experts);
        reg_slots   = 4'(slots);
        settings_used++;
    endtask

    task automatic check_field(string name, logic [COUNT_W-1:0] expected,
                               logic [COUNT_W-1:0] actual);
        if (actual !== expected)
        begin
            $error("%s: expected %0d, got %0d", name, expected, actual);
            fail_count++;
        end
    endtask

    task automatic test_fill_and_hit();
        send_req(mk_req(REQ_LOOKUP, 0, 5, 0, 0));
        send_req(mk_req(REQ_LOOKUP, 0, 5, 0, 0));
        send_req(mk_req(REQ_LOAD_DONE, 0, 5, 7, 1));
        send_req(mk_req(REQ_LOOKUP, 0, 5, 0, 0));
        send_req(mk_req(REQ_LOAD_DONE, 0, 9, 6, 0));
        send_req(mk_req(REQ_LOAD_DONE, 0, 9, 6, 1));
        repeat (3) send_req(mk_req(REQ_RELEASE, 0, 0, 7, 0));
        send_req(mk_req(REQ_LOOKUP, 63, 255, 7, 1));
        send_req(mk_req(REQ_LOAD_DONE, 63, 255, 7, 1));
        send_req(mk_req(REQ_RELEASE, 63, 255, 7, 1));
    endtask

    task automatic test_bad_keys();
        drain_results();
        set_regs(40, 200, 3);
        send_req(mk_req(REQ_LOOKUP, 63, 0, 0, 0));
        send_req(mk_req(REQ_LOOKUP, 0, 255, 0, 0));
        send_req(mk_req(REQ_LOAD_DONE, 0, 0, 7, 1));
        send_req(mk_req(REQ_LOAD_DONE, 1, 250, 0, 1));
        send_req(mk_req(REQ_RELEASE, 45, 0, 0, 0));
        send_req(mk_req(REQ_UNUSED, 63, 255, 7, 1));
        send_req(mk_req(REQ_LOOKUP, 39, 199, 0, 0));
    endtask

    task automatic test_slot_cap();
        drain_results();
        set_regs(64, 2, 8);
        send_req(mk_req(REQ_LOOKUP, 5, 1, 0, 0));
        send_req(mk_req(REQ_LOOKUP, 5, 0, 0, 0));
        send_req(mk_req(REQ_LOOKUP, 5, 1, 0, 0));
        send_req(mk_req(REQ_RELEASE, 5, 0, 2, 0));
        send_req(mk_req(REQ_LOAD_DONE, 5, 1, 1, 1));
        send_req(mk_req(REQ_LOOKUP, 5, 1, 0, 0));
        send_req(mk_req(REQ_LOAD_DONE, 5, 0, 0, 0));
        send_req(mk_req(REQ_LOOKUP, 5, 0, 0, 0));
    endtask

    task automatic test_lease_overflow();
        drain_results();
        set_regs(64, 256, 8);
        send_req(mk_req(REQ_LOOKUP, 62, 200, 0, 0));
        send_req(mk_req(REQ_LOAD_DONE, 62, 200, 7, 1));
        repeat (256) send_req(mk_req(REQ_LOOKUP, 62, 200, 0, 0));
        repeat (2) send_req(mk_req(REQ_RELEASE, 62, 0, 7, 0));
        send_req(mk_req(REQ_LOOKUP, 62, 200, 0, 0));
    endtask

    task automatic test_backpressure();
        drain_results();
        gaps_on         = 1'b0;
        rsp_hold_cycles = 80;
        repeat (30) send_req(random_req());
        drain_results();
        gaps_on = 1'b1;
    endtask

    task automatic test_random_traffic();
        int unsigned phase_regs [6][3];
        phase_regs = '{'{64, 256, 8}, '{1, 1, 1}, '{3, 12, 4}, '{64, 5, 8},
                       '{2, 256, 8}, '{7, 40, 2}};
        for (int p = 0; p < 6; p++)
        begin
            drain_results();
            set_regs(phase_regs[p][0], phase_regs[p][1], phase_regs[p][2]);
            for (int n = 0; n < 215; n++)
            begin
                if (n % 90 == 0)
                begin
                    gaps_on   = $urandom_range(0, 3) != 0;
                    stalls_on = $urandom_range(0, 3) != 0;
                end
                send_req(random_req());
            end
        end
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // result-side ready with random stalls and forced hold-offs
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rsp_hold_cycles != 0)
            begin
                rsp_ch.ready <= 1'b0;
                rsp_hold_cycles--;
            end
            else
            begin
                if (stall_left == 0 && stalls_on && $urandom_range(0, 99) < 25)
                    stall_left = idle_length();
                if (stall_left != 0)
                begin
                    rsp_ch.ready <= 1'b0;
                    stall_left--;
                end
                else
                    rsp_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (table_results_q.size() == 0)
            begin
                $error("result beat with nothing outstanding: status %0d", rsp_ch.status);
                fail_count++;
            end
            else
            begin
                exp_rsp = table_results_q.pop_front();
                results_checked++;
                status_seen[exp_rsp.status]++;
                check_field("status", COUNT_W'(exp_rsp.status), COUNT_W'(rsp_ch.status));
                check_field("slot_out", COUNT_W'(exp_rsp.slot), COUNT_W'(rsp_ch.slot_out));
                check_field("request_count", exp_rsp.requests, rsp_ch.request_count);
                check_field("hit_count", exp_rsp.hits, rsp_ch.hit_count);
                check_field("miss_count", exp_rsp.misses, rsp_ch.miss_count);
                check_field("resident_slots", COUNT_W'(exp_rsp.resident),
                            COUNT_W'(rsp_ch.resident_slots));
                check_field("lease_total", COUNT_W'(exp_rsp.leases),
                            COUNT_W'(rsp_ch.lease_total));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, table_results_q.size());
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        for (int k = 0; k < SLOT_COUNT; k++)
        begin
            tag_expert[k]  = '0;
            tag_valid[k]   = 1'b0;
            allocated[k]   = 1'b0;
            loading[k]     = 1'b0;
            lease_cnt[k]   = 0;
            fill_expert[k] = '0;
        end
        requests_cnt      = '0;
        hits_cnt          = '0;
        misses_cnt        = '0;
        resident_cnt      = 0;
        lease_sum         = 0;
        reg_layers        = 7'd64;
        reg_experts       = 9'd256;
        reg_slots         = 4'd8;
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = CFG_LAYERS;
        cfg_wdata         = '0;
        req_ch.valid      = 1'b0;
        req_ch.req_type   = REQ_LOOKUP;
        req_ch.layer      = '0;
        req_ch.expert_id  = '0;
        req_ch.slot_index = '0;
        req_ch.load_ok    = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_fill_and_hit();
        test_bad_keys();
        test_slot_cap();
        test_lease_overflow();
        test_backpressure();
        test_random_traffic();
        drain_results();
        repeat (8) @(posedge clk);
        $display("covered %0d requests over %0d register settings, %0d result beats checked",
                 items_sent, settings_used, results_checked);
        $display("by status: hit %0d fill %0d loaded %0d failed %0d no-free %0d",
                 status_seen[ST_HIT], status_seen[ST_FILL], status_seen[ST_LOADED],
                 status_seen[ST_FAILED], status_seen[ST_NOFREE],
                 " bad-key %0d released %0d overflow %0d",
                 status_seen[ST_BADKEY], status_seen[ST_RELEASED], status_seen[ST_OVERFLOW]);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// File: refcounted_slot_cache_table_top.f
design/rsc_pkg.sv
design/rsc_ifs.sv
design/rsc_ram.sv
design/refcounted_slot_cache_table_top.sv
tb/tb.sv
